[rtl/ltfs_pkg.sv]
// ============================================================================
// Lower-triangular forward solve package
// Shared types, constants and arithmetic helpers for the forward solver.
// ============================================================================
package ltfs_pkg;

   localparam int MaxStates = 16;
   localparam int IdxW      = $clog2(MaxStates);
   localparam int DataW     = 32;
   localparam int RecipW    = 49;  // quotient width for 2^48 / magnitude

   localparam logic [0:0] AddrActive = 1'b0;
   localparam logic [0:0] AddrScale  = 1'b1;

   localparam logic ModeLoad   = 1'b0;
   localparam logic ModeVector = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_DONE,
      ST_FETCH,
      ST_MAC,
      ST_ACCUM,
      ST_SUB,
      ST_RECIP,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Multiplier operand selection.
   typedef enum logic [1:0] {
      MUL_MAC,
      MUL_RECIP,
      MUL_SCALE
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;    // capture the accepted input item
      logic        div_start;    // initialise the reciprocal divider
      logic        div_step;     // one quotient bit
      logic        store_recip;  // write reciprocal of the diagonal
      logic        store_factor; // write the factor entry
      logic        clear_acc;    // start a new element
      logic        fetch;        // read factor and history at column j
      logic        mul_en;       // register the product
      mul_sel_type mul_sel;
      logic        acc_en;       // add the rounded product into the sum
      logic        sub_en;       // b minus sum, saturated
      logic        x_en;         // store solved element
      logic        out_load;     // fill output register
      logic        col_inc;
   } ctrl_type;

   typedef struct packed {
      logic mode;
      logic write_ok;      // factor write in range and on or below diagonal
      logic diag;
      logic div_done;
      logic col_done;      // column counter has reached the element index
   } status_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
      else                            return v[DataW-1:0];
   endfunction

   // Add half an LSB and floor-shift a Q.48 product down to Q.24.
   function automatic logic signed [41:0] round24(input logic signed [63:0] p);
      logic signed [64:0] t;
      t = {p[63], p} + 65'sd8388608;
      return {t[64], t[64:24]};
   endfunction

endpackage

[rtl/ltfs_ctrl.sv]
// ============================================================================
// Forward solve controller
// Sequences factor loads, the reciprocal division and the per-element
// multiply-accumulate loop.
// ============================================================================
module ltfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   input  ltfs_pkg::status_type status,
   output ltfs_pkg::ctrl_type   ctrl
);
   import ltfs_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            // Captured item decides the path.
            if (status.mode == ModeVector) state_in = ST_FETCH;
            else if (!status.write_ok) state_in = ST_IDLE;
            else if (!status.diag) state_in = ST_IDLE;
            else if (status.div_done) state_in = ST_DIV_DONE;
         end
         ST_DIV_DONE: state_in = ST_IDLE;
         ST_FETCH: begin
            if (status.col_done) state_in = ST_SUB;
            else state_in = ST_MAC;
         end
         ST_MAC:   state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_FETCH;
         ST_SUB:   state_in = ST_RECIP;
         ST_RECIP: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (!out_valid_ff || out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = MUL_MAC;
      in_ready = (state_ff == ST_IDLE);
      out_valid_in = out_valid_ff && !out_ready;
      case (state_ff)
         ST_IDLE: begin
            ctrl.load_item = in_valid;
            ctrl.div_start = in_valid;
            ctrl.clear_acc = in_valid;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            if (status.mode == ModeLoad && status.write_ok && !status.diag)
               ctrl.store_factor = 1'b1;
         end
         ST_DIV_DONE: begin
            ctrl.store_factor = 1'b1;
            ctrl.store_recip  = 1'b1;
         end
         ST_FETCH: ctrl.fetch = 1'b1;
         ST_MAC: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_MAC;
         end
         ST_ACCUM: begin
            ctrl.acc_en  = 1'b1;
            ctrl.col_inc = 1'b1;
         end
         ST_SUB: ctrl.sub_en = 1'b1;
         ST_RECIP: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_RECIP;
         end
         ST_SCALE: begin
            ctrl.x_en    = 1'b1;
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_SCALE;
         end
         ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               ctrl.out_load = 1'b1;
               out_valid_in  = 1'b1;
            end
         end
         default: ;
      endcase
      out_valid = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_item |-> state_ff == ST_IDLE)
      else $error("item captured outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff)
      else $error("result dropped while stalled");
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> (!out_valid_ff || out_ready))
      else $error("output register overwritten");
`endif
endmodule

[rtl/ltfs_datapath.sv]
// ============================================================================
// Forward solve datapath
// Factor and history stores, restoring divider, shared multiplier,
// accumulator and output register.
// ============================================================================
module ltfs_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ltfs_pkg::ctrl_type          ctrl,
   output ltfs_pkg::status_type        status,
   input  logic                       in_mode,
   input  logic [3:0]                 in_row,
   input  logic [3:0]                 in_col,
   input  logic signed [31:0]         in_value,
   input  logic [4:0]                 active_states,
   input  logic [30:0]                output_scale,
   output logic signed [31:0]         out_value,
   output logic [3:0]                 out_index,
   output logic                       out_last
);
   import ltfs_pkg::*;

   // Factor store: one write port, one registered read port.
   logic signed [DataW-1:0] factor_mem [MaxStates*MaxStates];
   logic signed [DataW-1:0] recip_mem  [MaxStates];
   logic signed [DataW-1:0] hist_mem   [MaxStates];

   logic               mode_ff;
   logic [3:0]         row_ff, col_ff;
   logic signed [31:0] value_ff;
   logic [IdxW-1:0]    elem_ff, elem_in;      // current element index
   logic [IdxW-1:0]    counter_ff, counter_in;
   logic [IdxW:0]      j_ff;
   logic               last_ff;

   logic signed [31:0] fac_rd_ff, hist_rd_ff, recip_rd_ff;
   logic signed [63:0] prod_ff, mul_res;
   logic signed [31:0] mul_a, mul_b;
   logic signed [43:0] sum_ff;   // 15 rounded terms of up to 40 bits
   logic signed [31:0] acc_ff;
   logic signed [31:0] x_in_mul;
   logic signed [31:0] out_value_ff;
   logic [3:0]         out_index_ff;
   logic               out_last_ff;

   // Restoring divider for 2^48 / |value|.
   logic [RecipW-1:0]  quot_ff;
   logic [32:0]        rem_ff;
   logic [5:0]         dcnt_ff;
   logic [32:0]        rem_shift;
   logic [32:0]        divisor;
   logic               neg_ff;
   logic [RecipW:0]    signed_q;
   logic signed [31:0] recip_val;

   logic [4:0] n_act;
   always_comb begin
      n_act = active_states;
      if (n_act == 5'd0) n_act = 5'd1;
      if (n_act > 5'(MaxStates)) n_act = 5'(MaxStates);
      elem_in = (5'(counter_ff) >= n_act) ? '0 : counter_ff;
      counter_in = (5'(elem_in) + 5'd1 >= n_act) ? '0 : elem_in + 1'b1;
   end

   assign divisor = value_ff[31] ? 33'(-{value_ff[31], value_ff}) : {1'b0, value_ff};
   // Dividend is a single one at bit 48.
   assign rem_shift = {rem_ff[31:0], (dcnt_ff == 6'd0)};

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         mode_ff  <= in_mode;
         row_ff   <= in_row;
         col_ff   <= in_col;
         value_ff <= in_value;
         neg_ff   <= in_value[31];
      end
      if (reset) begin
         dcnt_ff <= '0;
      end else if (ctrl.div_start) begin
         quot_ff <= '0;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (ctrl.div_step && !status.div_done) begin
         if (rem_shift >= divisor) begin
            rem_ff  <= rem_shift - divisor;
            quot_ff <= {quot_ff[RecipW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            quot_ff <= {quot_ff[RecipW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   always_comb begin
      signed_q = neg_ff ? -{1'b0, quot_ff} : {1'b0, quot_ff};
      if (value_ff == 32'sd0) recip_val = 32'sh7FFF_FFFF;
      else recip_val = sat32(66'(signed'(signed_q)));
   end

   // The solved element comes straight from the recip product register.
   assign x_in_mul = sat32(66'(round24(prod_ff)));

   always_ff @(posedge clock) begin
      if (ctrl.store_factor) factor_mem[{row_ff, col_ff}] <= value_ff;
      if (ctrl.store_recip)  recip_mem[row_ff] <= recip_val;
      if (ctrl.fetch) begin
         fac_rd_ff  <= factor_mem[{elem_ff, j_ff[IdxW-1:0]}];
         hist_rd_ff <= hist_mem[j_ff[IdxW-1:0]];
      end
      if (ctrl.sub_en) recip_rd_ff <= recip_mem[elem_ff];
      if (ctrl.x_en) hist_mem[elem_ff] <= x_in_mul;
   end

   always_comb begin
      case (ctrl.mul_sel)
         MUL_MAC:   begin mul_a = fac_rd_ff; mul_b = hist_rd_ff; end
         MUL_RECIP: begin mul_a = acc_ff;    mul_b = recip_rd_ff; end
         MUL_SCALE: begin mul_a = x_in_mul;  mul_b = {1'b0, output_scale}; end
         default:   begin mul_a = fac_rd_ff; mul_b = hist_rd_ff; end
      endcase
      mul_res = 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) prod_ff <= mul_res;
      if (ctrl.clear_acc) begin
         sum_ff <= '0;
         j_ff   <= '0;
      end else begin
         if (ctrl.acc_en) sum_ff <= sum_ff + round24(prod_ff);
         if (ctrl.col_inc) j_ff <= j_ff + 1'b1;
      end
      if (ctrl.sub_en)
         acc_ff <= sat32(66'(value_ff) - 66'(sum_ff));
      if (ctrl.out_load) begin
         out_value_ff <= sat32(66'(round24(prod_ff)));
         out_index_ff <= 4'(elem_ff);
         out_last_ff  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         elem_ff    <= '0;
         last_ff    <= 1'b0;
      end else if (ctrl.load_item && in_mode == ModeVector) begin
         elem_ff    <= elem_in;
         last_ff    <= (5'(elem_in) + 5'd1 == n_act);
         counter_ff <= counter_in;
      end
   end

   always_comb begin
      status.mode     = mode_ff;
      status.write_ok = (col_ff <= row_ff);
      status.diag     = (col_ff == row_ff);
      status.div_done = (dcnt_ff == 6'(RecipW));
      status.col_done = (j_ff[IdxW-1:0] == elem_ff) || j_ff[IdxW];
   end

   assign out_value = out_value_ff;
   assign out_index = out_index_ff;
   assign out_last  = out_last_ff;

`ifndef SYNTHESIS
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      5'(counter_ff) < 5'(MaxStates) + 5'd1)
      else $error("element counter out of range");
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.acc_en |-> j_ff[IdxW-1:0] < elem_ff || j_ff[IdxW])
      else $error("accumulated past the diagonal");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= 6'(RecipW))
      else $error("divider ran too long");
`endif
endmodule

[rtl/lower_triangular_forward_solve.sv]
// ============================================================================
// Lower-triangular forward solve
// Applies the inverse of a loaded lower-triangular factor to vectors.
// ============================================================================
// A factor write on the diagonal also runs a bit-serial divider that forms
// the 2^48 reciprocal one quotient bit a cycle. For element i of a vector,
// one shared 32x32 multiplier works through the i earlier solved elements,
// reading, multiplying and adding for each, then applies the reciprocal and
// the output scale. One item is in flight at a time; a finished result
// waits in the output register while the next item is taken.
module lower_triangular_forward_solve (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // factor_row[3:0], factor_col[7:4], value[39:8]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // solved_value[31:0], element_index[35:32]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ltfs_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   logic [4:0]  active_ff;
   logic [30:0] scale_ff;
   logic signed [31:0] out_value;
   logic [3:0] out_index;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'd16;
         scale_ff  <= 31'd16777216;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == AddrActive) active_ff <= csr_pwdata[4:0];
         else scale_ff <= csr_pwdata[30:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == AddrScale) csr_prdata = {1'b0, scale_ff};
      else csr_prdata = {27'd0, active_ff};
   end

   ltfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .ctrl      (ctrl)
   );

   ltfs_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .in_mode       (req_tuser),
      .in_row        (req_tdata[3:0]),
      .in_col        (req_tdata[7:4]),
      .in_value      (req_tdata[39:8]),
      .active_states (active_ff),
      .output_scale  (scale_ff),
      .out_value     (out_value),
      .out_index     (out_index),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, out_index, out_value};
endmodule
